FILE: src/dmae_pkg.sv
// ----------------------------------------------------------------------------
// dmae_pkg
// Shared types, codes and constants of the Data Matrix ASCII encoder unit.
// ----------------------------------------------------------------------------
package dmae_pkg;

    localparam int CW_W   = 8;   // codeword and byte width
    localparam int CNT_W  = 11;  // codeword counter and capacity width
    localparam int RAND_W = 8;   // randomizer residue width

    // The codeword counter saturates here.
    localparam logic [CNT_W-1:0] COUNT_LIMIT = 11'd2047;

    localparam logic [CW_W-1:0] CW_PAD         = 8'd129;
    localparam logic [CW_W-1:0] CW_PAIR_BASE   = 8'd130;
    localparam logic [CW_W-1:0] CW_FNC1        = 8'd232;
    localparam logic [CW_W-1:0] CW_UPPER_SHIFT = 8'd235;
    localparam logic [CW_W-1:0] EXT_OFFSET     = 8'd127;
    localparam logic [CW_W-1:0] DIGIT_ZERO     = 8'd48;
    localparam logic [CW_W-1:0] DIGIT_NINE     = 8'd57;

    // 253-state randomizer constants.
    localparam logic [RAND_W:0]   RAND_STEP = 9'd149;
    localparam logic [RAND_W:0]   RAND_MOD  = 9'd253;
    localparam logic [RAND_W:0]   RAND_WRAP = 9'd254;
    // Residue of 149 * 1 mod 253, the value for the first codeword position.
    localparam logic [RAND_W-1:0] RAND_INIT = 8'd149;

    typedef enum logic [1:0] {
        CMD_DATA = 2'd0,
        CMD_END  = 2'd1,
        CMD_PAD  = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CODEWORD   = 2'd0,
        ST_NO_COMPACT = 2'd1,
        ST_FULL       = 2'd2,
        ST_OVERFLOW   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_EXPANDED = 2'd1,
        MODE_COMPACT  = 2'd2,
        MODE_ALT      = 2'd3   // behaves as normal pairing
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MODE      = 2'd0,
        CFG_FNC1_EN   = 2'd1,
        CFG_FNC1_CHAR = 2'd2,
        CFG_CAPACITY  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        mode_t            mode;
        logic             fnc1_en;
        logic [CW_W-1:0]  fnc1_char;
        logic [CNT_W-1:0] capacity;
    } cfg_t;

    typedef struct packed {
        logic [CW_W-1:0]   pending_byte;
        logic              pending_valid;
        logic [CNT_W-1:0]  count;
        // (149 * (count + 1)) mod 253, kept in step with count.
        logic [RAND_W-1:0] rand_res;
        logic              pad_started;
        logic              stream_invalid;
    } enc_state_t;

    typedef struct packed {
        logic [CW_W-1:0] codeword;
        status_t         status;
        logic            last;
    } result_t;

    // Advance the randomizer residue by one codeword position.
    function automatic logic [RAND_W-1:0] rand_advance(input logic [RAND_W-1:0] r);
        logic [RAND_W:0] s;
        s = {1'b0, r} + RAND_STEP;
        if (s >= RAND_MOD) begin
            s = s - RAND_MOD;
        end
        return s[RAND_W-1:0];
    endfunction

endpackage

FILE: src/dmae_step.sv
// ----------------------------------------------------------------------------
// dmae_step
// Encoding logic for one item: results and next encoder state.
// ----------------------------------------------------------------------------
module dmae_step (
    input  dmae_pkg::cmd_t             cmd,
    input  logic [dmae_pkg::CW_W-1:0]  data_byte,
    input  dmae_pkg::cfg_t             cfg,
    input  dmae_pkg::enc_state_t       st,
    output dmae_pkg::enc_state_t       st_next,
    output logic [1:0]                 n_res,
    output dmae_pkg::result_t          res0,
    output dmae_pkg::result_t          res1
);
    import dmae_pkg::*;

    logic              pb_fnc1, b_fnc1, pb_digit, b_digit, pair_ok;
    logic [CW_W-1:0]   pb, pair_cw;
    logic [1:0]        single_n;
    logic [CW_W-1:0]   single_cw0, single_cw1;
    logic              inc1, inc2;
    logic [CNT_W-1:0]  cnt1, cnt2;
    logic [RAND_W-1:0] rnd1, rnd2;
    logic [RAND_W:0]   pad_sum;
    logic [CW_W-1:0]   pad_cw;
    status_t           stat_a, stat_b;
    logic [1:0]        n_cw;

    assign pb       = st.pending_byte;
    assign pb_fnc1  = cfg.fnc1_en && (pb == cfg.fnc1_char);
    assign b_fnc1   = cfg.fnc1_en && (data_byte == cfg.fnc1_char);
    assign pb_digit = (pb >= DIGIT_ZERO) && (pb <= DIGIT_NINE);
    assign b_digit  = (data_byte >= DIGIT_ZERO) && (data_byte <= DIGIT_NINE);
    assign pair_ok  = (cfg.mode != MODE_EXPANDED) && pb_digit && b_digit
                      && !pb_fnc1 && !b_fnc1;

    // 130 + 10 * first digit + second digit; the low nibble holds the digit value.
    assign pair_cw = CW_PAIR_BASE + {1'b0, pb[3:0], 3'b000} + {3'b000, pb[3:0], 1'b0}
                     + {4'b0000, data_byte[3:0]};

    // Lone encoding of the pending byte.
    always_comb begin
        single_cw1 = '0;
        if (pb_fnc1) begin
            single_n   = 2'd1;
            single_cw0 = CW_FNC1;
        end else if (!pb[CW_W-1]) begin
            single_n   = 2'd1;
            single_cw0 = pb + 8'd1;
        end else begin
            single_n   = 2'd2;
            single_cw0 = CW_UPPER_SHIFT;
            single_cw1 = pb - EXT_OFFSET;
        end
    end

    // Counter and randomizer after the first and second emitted codeword.
    assign inc1   = (st.count != COUNT_LIMIT);
    assign cnt1   = inc1 ? st.count + 11'd1 : st.count;
    assign rnd1   = inc1 ? rand_advance(st.rand_res) : st.rand_res;
    assign inc2   = (cnt1 != COUNT_LIMIT);
    assign cnt2   = inc2 ? cnt1 + 11'd1 : cnt1;
    assign rnd2   = inc2 ? rand_advance(rnd1) : rnd1;
    assign stat_a = (st.count >= cfg.capacity) ? ST_OVERFLOW : ST_CODEWORD;
    assign stat_b = (cnt1 >= cfg.capacity) ? ST_OVERFLOW : ST_CODEWORD;

    // Randomized pad: 129 + residue + 1, wrapped above 254.
    assign pad_sum = {1'b0, st.rand_res} + {1'b0, CW_PAIR_BASE};
    assign pad_cw  = (pad_sum > RAND_WRAP) ? 8'(pad_sum - RAND_WRAP) : pad_sum[CW_W-1:0];

    always_comb begin
        st_next       = st;
        n_res         = 2'd0;
        n_cw          = 2'd0;
        res0.codeword = '0;
        res0.status   = ST_CODEWORD;
        res1.codeword = '0;
        res1.status   = ST_CODEWORD;

        if (cmd == CMD_NOP) begin
            n_res = 2'd0;
        end else if (st.stream_invalid) begin
            n_res       = 2'd1;
            res0.status = ST_NO_COMPACT;
        end else if (cmd == CMD_DATA) begin
            if (st.pad_started) begin
                n_res = 2'd0;
            end else if (!st.pending_valid) begin
                st_next.pending_byte  = data_byte;
                st_next.pending_valid = 1'b1;
            end else if (pair_ok) begin
                st_next.pending_valid = 1'b0;
                n_cw                  = 2'd1;
                res0.codeword         = pair_cw;
            end else if (cfg.mode == MODE_COMPACT) begin
                st_next.stream_invalid = 1'b1;
                st_next.pending_valid  = 1'b0;
                n_res                  = 2'd1;
                res0.status            = ST_NO_COMPACT;
            end else begin
                st_next.pending_byte = data_byte;
                n_cw                 = single_n;
                res0.codeword        = single_cw0;
                res1.codeword        = single_cw1;
            end
        end else if (cmd == CMD_END || st.pending_valid) begin
            // Flush; a pad item with a byte pending does only this.
            if (!st.pending_valid) begin
                n_res = 2'd0;
            end else if (cfg.mode == MODE_COMPACT) begin
                st_next.stream_invalid = 1'b1;
                st_next.pending_valid  = 1'b0;
                n_res                  = 2'd1;
                res0.status            = ST_NO_COMPACT;
            end else begin
                st_next.pending_valid = 1'b0;
                n_cw                  = single_n;
                res0.codeword         = single_cw0;
                res1.codeword         = single_cw1;
            end
        end else if (st.count >= cfg.capacity) begin
            n_res       = 2'd1;
            res0.status = ST_FULL;
        end else if (!st.pad_started) begin
            st_next.pad_started = 1'b1;
            n_cw                = 2'd1;
            res0.codeword       = CW_PAD;
        end else begin
            n_cw          = 2'd1;
            res0.codeword = pad_cw;
        end

        if (n_cw != 2'd0) begin
            n_res       = n_cw;
            res0.status = stat_a;
            res1.status = stat_b;
            if (n_cw == 2'd2) begin
                st_next.count    = cnt2;
                st_next.rand_res = rnd2;
            end else begin
                st_next.count    = cnt1;
                st_next.rand_res = rnd1;
            end
        end

        res0.last = (n_res == 2'd1);
        res1.last = 1'b1;
    end

endmodule

FILE: src/dmae_obuf.sv
// ----------------------------------------------------------------------------
// dmae_obuf
// Two-slot result register that holds the words of one item for the output.
// ----------------------------------------------------------------------------
module dmae_obuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic [1:0]         n_res,
    input  dmae_pkg::result_t  res0,
    input  dmae_pkg::result_t  res1,
    output logic               free,
    output logic               out_valid,
    input  logic               out_ready,
    output dmae_pkg::result_t  out_word
);
    import dmae_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       fire;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_word  = slot0_reg;
    assign fire      = out_valid && out_ready;
    // Room for a new item once the slots are empty or drain this cycle.
    assign free      = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);

    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load) begin
            cnt_next   = n_res;
            slot0_next = res0;
            slot1_next = res1;
        end else if (fire) begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

FILE: src/datamatrix_ascii_encoder_unit.sv
// ----------------------------------------------------------------------------
// datamatrix_ascii_encoder_unit
// Data Matrix ASCII encodation of a byte stream, with FNC1, modes and padding.
// ----------------------------------------------------------------------------
// An input word carries a command in s_tuser (data byte, end of data, pad step)
// and a byte in s_tdata. Each word passes through an input register, is
// encoded combinationally against the encoder state, and its zero, one or two
// result words land in a two-slot output register. m_tlast marks the final
// word caused by an input word, m_tuser carries its status. A byte is held
// pending until the next byte arrives so that digit pairs can merge. The unit
// takes one input word per cycle while m_tready is high and each word
// produces at most one result word; a word that produces two (upper shift)
// holds the single output port for both, and the next input word waits until
// the first has left. Configuration is written through cfg_wr_en, cfg_addr
// and cfg_wr_data; the user must write it only while the unit is idle, which
// the unit does not enforce. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module datamatrix_ascii_encoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [10:0] cfg_wr_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [1:0]  s_tuser,    // [1:0] cmd
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] codeword
    output logic [1:0]  m_tuser,    // [1:0] status
    output logic        m_tlast
);
    import dmae_pkg::*;

    cfg_t             cfg_reg;
    enc_state_t       st_reg, st_next;
    logic             in_valid_reg;
    cmd_t             cmd_reg;
    logic [CW_W-1:0]  byte_reg;
    logic             ob_free, go;
    logic [1:0]       n_res;
    result_t          res0, res1, out_word;

    // The input register frees up whenever the held word is encoded.
    assign go       = in_valid_reg && ob_free;
    assign s_tready = !in_valid_reg || ob_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (go) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            cmd_reg  <= cmd_t'(s_tuser);
            byte_reg <= s_tdata;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode      <= MODE_NORMAL;
            cfg_reg.fnc1_en   <= 1'b0;
            cfg_reg.fnc1_char <= '0;
            cfg_reg.capacity  <= 11'd3;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MODE:      cfg_reg.mode      <= mode_t'(cfg_wr_data[1:0]);
                CFG_FNC1_EN:   cfg_reg.fnc1_en   <= cfg_wr_data[0];
                CFG_FNC1_CHAR: cfg_reg.fnc1_char <= cfg_wr_data[CW_W-1:0];
                CFG_CAPACITY:  cfg_reg.capacity  <= cfg_wr_data;
            endcase
        end
    end

    dmae_step u_step (
        .cmd       (cmd_reg),
        .data_byte (byte_reg),
        .cfg       (cfg_reg),
        .st        (st_reg),
        .st_next   (st_next),
        .n_res     (n_res),
        .res0      (res0),
        .res1      (res1)
    );

    // Encoder state advances only when a word is encoded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.pending_byte   <= '0;
            st_reg.pending_valid  <= 1'b0;
            st_reg.count          <= '0;
            st_reg.rand_res       <= RAND_INIT;
            st_reg.pad_started    <= 1'b0;
            st_reg.stream_invalid <= 1'b0;
        end else if (go) begin
            st_reg <= st_next;
        end
    end

    dmae_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (go),
        .n_res     (n_res),
        .res0      (res0),
        .res1      (res1),
        .free      (ob_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = out_word.codeword;
    assign m_tuser = out_word.status;
    assign m_tlast = out_word.last;

`ifndef SYNTHESIS
    // A broken compact stream stays broken until reset.
    a_invalid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.stream_invalid |=> st_reg.stream_invalid)
        else $error("stream_invalid cleared without reset");

    // Once padding has begun no byte can be pending.
    a_pad_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.pad_started |-> !st_reg.pending_valid)
        else $error("byte pending after padding started");

    // Error and full results carry a zero codeword.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_NO_COMPACT || m_tuser == ST_FULL)) |->
        (m_tdata == '0))
        else $error("nonzero codeword on error or full result");

    // The randomizer residue stays below its modulus.
    a_rand_range: assert property (@(posedge aclk) disable iff (!aresetn)
        go |=> ({1'b0, st_reg.rand_res} < RAND_MOD))
        else $error("randomizer residue out of range");
`endif

endmodule
